### design/hbbpc_pkg.sv
// ----------------------------------------------------------------------------
// hbbpc_pkg
// Shared types and constants of the homing bang-bang position controller.
// ----------------------------------------------------------------------------
`default_nettype none

package hbbpc_pkg;

    // target assembly
    localparam int TARGET_BYTES_DEF = 4;
    localparam int BYTE_CNT_W       = 3;
    localparam int POS_W            = 32;
    localparam int BYTE_W           = 8;
    localparam int TARGET_LANES     = POS_W / BYTE_W;

    // configuration port
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int DEADBAND_W  = 16;
    localparam int SPEED_W     = 8;

    localparam logic [DEADBAND_W-1:0] DEADBAND_RST = 16'd7;
    localparam logic [SPEED_W-1:0]    SPEED_RST    = 8'd255;

    // register index, taken from paddr[2]
    typedef enum logic {
        REG_DEADBAND = 1'b0,
        REG_SPEED    = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_BYTE    = 2'd1,
        CMD_ENCODER = 2'd2,
        CMD_LIMIT   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        MODE_HOMING = 2'd0,
        MODE_READY  = 2'd1,
        MODE_MOVING = 2'd2,
        MODE_FAULT  = 2'd3
    } t_mode;

    typedef struct packed {
        logic [1:0]        command;
        logic [BYTE_W-1:0] data_byte;
        logic              encoder_dir;
    } t_in_item;

    typedef struct packed {
        logic              motor_run;
        logic              drive_fwd;
        logic [SPEED_W-1:0] drive_compare;
        logic              busy_res;
        logic [1:0]        mode;
        logic [POS_W-1:0]  position;
    } t_out_item;

    typedef struct packed {
        logic [DEADBAND_W-1:0] deadband;
        logic [SPEED_W-1:0]    drive_speed;
    } t_cfg;

    typedef struct packed {
        t_mode mode;
        logic  run;
    } t_status;

endpackage

`default_nettype wire

### design/homing_bang_bang_position_controller.sv
// path of an accepted item: input register, core, result register
// throughput: one item per cycle while o_in_stall is low; the state update
// of the core, closed through its state registers, is the loop setting it
// an output stall holds the input back as soon as both registers are full
// reset (synchronous, active low): homing, motor running in reverse,
// position and target zero, deadband 7, drive speed 255, both channels empty
`default_nettype none

// ----------------------------------------------------------------------------
// homing_bang_bang_position_controller
// Top level: input register, controller core, result register and the
// configuration port.
// ----------------------------------------------------------------------------
module homing_bang_bang_position_controller
    import hbbpc_pkg::*;
#(
    parameter int TARGET_BYTES = TARGET_BYTES_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  t_in_item                   i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_out_item                  o_out_data,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    logic      advance;
    t_cfg      cfg;
    t_out_item result;
    t_status   status;

    // an item moves on when the result register is free or being drained
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_item <= i_in_data;
        end
    end

    hbbpc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    hbbpc_core #(
        .TARGET_BYTES (TARGET_BYTES)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (result),
        .o_status (status)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

`ifndef SYNTHESIS
    // a latched fault is left only through reset
    a_fault_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.mode == MODE_FAULT |=> status.mode == MODE_FAULT)
        else $error("fault mode left without reset");

    // homing is never re-entered once done
    a_homing_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.mode != MODE_HOMING |=> status.mode != MODE_HOMING)
        else $error("homing re-entered");

    // a stopped motor shows a zero compare value
    a_stop_compare: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.motor_run |-> o_out_data.drive_compare == '0)
        else $error("compare value nonzero while stopped");

    // input side stalls only behind a full, stalled result register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_out_valid && i_out_stall && r_in_valid)
        else $error("input stalled with room downstream");
`endif

endmodule

`default_nettype wire

### design/hbbpc_cfg.sv
// ----------------------------------------------------------------------------
// hbbpc_cfg
// Configuration registers behind an APB-style port: deadband and drive speed.
// ----------------------------------------------------------------------------
`default_nettype none

module hbbpc_cfg
    import hbbpc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready,
    output t_cfg                       o_cfg
);

    logic [DEADBAND_W-1:0] r_deadband;
    logic [SPEED_W-1:0]    r_drive_speed;
    logic                  wr_en;
    t_reg_idx              reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[2]);

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadband    <= DEADBAND_RST;
            r_drive_speed <= SPEED_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_DEADBAND: r_deadband    <= pwdata[DEADBAND_W-1:0];
                REG_SPEED:    r_drive_speed <= pwdata[SPEED_W-1:0];
                default:      r_deadband    <= r_deadband;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (reg_idx)
            REG_DEADBAND: prdata = APB_DATA_W'(r_deadband);
            REG_SPEED:    prdata = APB_DATA_W'(r_drive_speed);
            default:      prdata = '0;
        endcase
    end

    assign o_cfg.deadband    = r_deadband;
    assign o_cfg.drive_speed = r_drive_speed;

endmodule

`default_nettype wire

### design/hbbpc_core.sv
// ----------------------------------------------------------------------------
// hbbpc_core
// Controller state and the single-pass update: event handling, target
// assembly, deadband check and drive outputs for one item.
// ----------------------------------------------------------------------------
`default_nettype none

module hbbpc_core
    import hbbpc_pkg::*;
#(
    parameter int TARGET_BYTES = TARGET_BYTES_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_step,
    input  t_in_item      i_item,
    input  t_cfg          i_cfg,
    output t_out_item     o_result,
    output t_status       o_status
);

    localparam logic [BYTE_CNT_W:0] FRAME_LEN = (BYTE_CNT_W+1)'(TARGET_BYTES);

    t_mode                 r_mode,   n_mode;
    logic [POS_W-1:0]      r_pos,    n_pos;
    logic [POS_W-1:0]      r_target, n_target;
    logic [BYTE_CNT_W-1:0] r_cnt,    n_cnt;
    logic                  r_run,    n_run;
    logic                  r_dir,    n_dir;

    t_mode                 ev_mode;
    logic                  ev_run;
    logic [BYTE_CNT_W:0]   cnt_inc;
    logic [POS_W-1:0]      diff;
    logic [POS_W-1:0]      mag;
    logic                  neg;

    assign cnt_inc = {1'b0, r_cnt} + 1'b1;

    // event handling, then the control check on the updated state
    always_comb begin
        ev_mode  = r_mode;
        ev_run   = r_run;
        n_pos    = r_pos;
        n_target = r_target;
        n_cnt    = r_cnt;
        n_dir    = r_dir;

        unique case (t_cmd'(i_item.command))
            CMD_BYTE: begin
                if (r_mode == MODE_READY) begin
                    // lanes past the target width are dropped
                    for (int l = 0; l < TARGET_LANES; l++) begin
                        if (r_cnt == BYTE_CNT_W'(l)) begin
                            n_target[l*BYTE_W +: BYTE_W] = i_item.data_byte;
                        end
                    end
                    if (cnt_inc >= FRAME_LEN) begin
                        n_cnt   = '0;
                        ev_mode = MODE_MOVING;
                    end else begin
                        n_cnt = cnt_inc[BYTE_CNT_W-1:0];
                    end
                end
            end
            CMD_ENCODER: begin
                n_pos = i_item.encoder_dir ? r_pos + 1'b1 : r_pos - 1'b1;
            end
            CMD_LIMIT: begin
                ev_run = 1'b0;
                if (r_mode == MODE_HOMING) begin
                    n_pos   = '0;
                    ev_mode = MODE_READY;
                end else begin
                    ev_mode = MODE_FAULT;
                end
            end
            default: begin
            end
        endcase

        // wrapping error and its magnitude
        diff = n_target - n_pos;
        neg  = diff[POS_W-1];
        mag  = neg ? (~diff + 1'b1) : diff;

        n_mode = ev_mode;
        n_run  = ev_run;
        if (ev_mode == MODE_MOVING) begin
            if (mag < POS_W'(i_cfg.deadband)) begin
                n_run  = 1'b0;
                n_mode = MODE_READY;
            end else begin
                n_run = 1'b1;
                n_dir = !neg && (diff != '0);
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_HOMING;
            r_pos    <= '0;
            r_target <= '0;
            r_cnt    <= '0;
            r_run    <= 1'b1;
            r_dir    <= 1'b0;
        end else if (i_step) begin
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_target <= n_target;
            r_cnt    <= n_cnt;
            r_run    <= n_run;
            r_dir    <= n_dir;
        end
    end

    // result for this item
    assign o_result.motor_run     = n_run;
    assign o_result.drive_fwd     = n_dir;
    assign o_result.drive_compare = n_run ? i_cfg.drive_speed : '0;
    assign o_result.busy_res      = (n_mode != MODE_READY);
    assign o_result.mode          = n_mode;
    assign o_result.position      = n_pos;

    assign o_status.mode = r_mode;
    assign o_status.run  = r_run;

endmodule

`default_nettype wire

### test/homing_bang_bang_position_controller_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// homing_bang_bang_position_controller_test
// Drives events into the controller and checks every drive report against the
// table or a behavioural copy of the controller in the bench. A short table
// covers homing, target frames, the deadband edge and the fault latch; random
// phases then run steered moves under several deadband and speed settings,
// with random gaps on the event side and random stalls on the report side.
// ----------------------------------------------------------------------------
module homing_bang_bang_position_controller_test;
    import hbbpc_pkg::*;

    localparam int N_PHASES      = 6;
    localparam int DIRECTED_ROWS = 23;
    localparam int TABLE_ROWS    = 27;
    localparam int PHASE_DEADBAND [N_PHASES] = '{1, 65535, 0, 3, 40, 20};
    localparam int PHASE_SPEED    [N_PHASES] = '{0, 128, 200, 1, 99, 255};
    localparam int PHASE_ITEMS    [N_PHASES] = '{160, 160, 60, 160, 160, 150};
    localparam t_out_item NONE = '0;

    typedef struct packed {
        t_in_item  ev;
        logic      given;
        t_out_item want;
    } t_event_row;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    t_in_item              i_in_data   = '0;
    logic                  i_out_stall = 1'b0;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [APB_ADDR_W-1:0] paddr       = '0;
    logic [APB_DATA_W-1:0] pwdata      = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out_item             o_out_data;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // controller state as the bench sees it
    t_mode                 ctl_mode     = MODE_HOMING;
    logic [POS_W-1:0]      enc_position = '0;
    logic [POS_W-1:0]      target_pos   = '0;
    logic [BYTE_CNT_W-1:0] frame_count  = '0;
    logic                  motor_on     = 1'b1;
    logic                  motor_fwd    = 1'b0;
    logic [DEADBAND_W-1:0] deadband_now = DEADBAND_RST;
    logic [SPEED_W-1:0]    speed_now    = SPEED_RST;

    t_out_item   drive_reports [$];
    logic [7:0]  frame_bytes [$];
    t_out_item   report_due;
    int          mismatches = 0;
    int          stall_left = 0;
    bit          idle_on    = 1'b1;

    t_event_row event_table [TABLE_ROWS] = '{
        // homing: reverse at full speed, edges counted and wrapping, bytes ignored
        '{'{CMD_TICK,    8'h00, 1'b0}, 1'b1, '{1'b1, 1'b0, 8'd255, 1'b1, MODE_HOMING, 32'h0}},
        '{'{CMD_ENCODER, 8'hFF, 1'b1}, 1'b1, '{1'b1, 1'b0, 8'd255, 1'b1, MODE_HOMING, 32'h1}},
        '{'{CMD_ENCODER, 8'h00, 1'b0}, 1'b1, '{1'b1, 1'b0, 8'd255, 1'b1, MODE_HOMING, 32'h0}},
        '{'{CMD_ENCODER, 8'h00, 1'b0}, 1'b1,
          '{1'b1, 1'b0, 8'd255, 1'b1, MODE_HOMING, 32'hFFFF_FFFF}},
        '{'{CMD_BYTE,    8'hFF, 1'b1}, 1'b1,
          '{1'b1, 1'b0, 8'd255, 1'b1, MODE_HOMING, 32'hFFFF_FFFF}},
        // first limit hit: stop, clear position, ready
        '{'{CMD_LIMIT,   8'h00, 1'b0}, 1'b1, '{1'b0, 1'b0, 8'd0, 1'b0, MODE_READY, 32'h0}},
        // target 10, forward move, a byte while moving is ignored
        '{'{CMD_BYTE,    8'h0A, 1'b0}, 1'b0, NONE},
        '{'{CMD_BYTE,    8'h00, 1'b0}, 1'b0, NONE},
        '{'{CMD_BYTE,    8'h00, 1'b0}, 1'b0, NONE},
        '{'{CMD_BYTE,    8'h00, 1'b0}, 1'b0, NONE},
        '{'{CMD_BYTE,    8'h55, 1'b0}, 1'b0, NONE},
        // error 9, 8, 7 outside the deadband, 6 inside
        '{'{CMD_ENCODER, 8'h00, 1'b1}, 1'b0, NONE},
        '{'{CMD_ENCODER, 8'h00, 1'b1}, 1'b0, NONE},
        '{'{CMD_ENCODER, 8'h00, 1'b1}, 1'b0, NONE},
        '{'{CMD_ENCODER, 8'h00, 1'b1}, 1'b0, NONE},
        // target already inside the deadband: frame ends ready at once
        '{'{CMD_BYTE,    8'h00, 1'b0}, 1'b0, NONE},
        '{'{CMD_BYTE,    8'h00, 1'b0}, 1'b0, NONE},
        '{'{CMD_BYTE,    8'h00, 1'b0}, 1'b0, NONE},
        '{'{CMD_BYTE,    8'h00, 1'b0}, 1'b0, NONE},
        // target below the position: reverse move
        '{'{CMD_BYTE,    8'hF0, 1'b0}, 1'b0, NONE},
        '{'{CMD_BYTE,    8'hFF, 1'b0}, 1'b0, NONE},
        '{'{CMD_BYTE,    8'hFF, 1'b0}, 1'b0, NONE},
        '{'{CMD_BYTE,    8'hFF, 1'b0}, 1'b0, NONE},
        // closing: limit after homing latches the fault, which nothing clears
        '{'{CMD_LIMIT,   8'h00, 1'b0}, 1'b0, NONE},
        '{'{CMD_LIMIT,   8'hA5, 1'b1}, 1'b0, NONE},
        '{'{CMD_ENCODER, 8'h00, 1'b0}, 1'b0, NONE},
        '{'{CMD_TICK,    8'h00, 1'b0}, 1'b0, NONE}
    };

    homing_bang_bang_position_controller DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // one event into the controller state, returns the drive report it gives
    function automatic t_out_item step_controller(t_in_item ev);
        t_out_item        r;
        int               lane;
        logic [POS_W-1:0] diff;
        logic [POS_W-1:0] mag;
        logic             neg;
        case (ev.command)
            CMD_BYTE: begin
                if (ctl_mode == MODE_READY) begin
                    lane = int'(frame_count);
                    if (lane < TARGET_LANES)
                        target_pos[lane*BYTE_W +: BYTE_W] = ev.data_byte;
                    lane = lane + 1;
                    if (lane >= TARGET_BYTES_DEF) begin
                        frame_count = '0;
                        ctl_mode    = MODE_MOVING;
                    end else begin
                        frame_count = BYTE_CNT_W'(lane);
                    end
                end
            end
            CMD_ENCODER: begin
                enc_position = ev.encoder_dir ? enc_position + 1 : enc_position - 1;
            end
            CMD_LIMIT: begin
                motor_on = 1'b0;
                if (ctl_mode == MODE_HOMING) begin
                    enc_position = '0;
                    ctl_mode     = MODE_READY;
                end else begin
                    ctl_mode = MODE_FAULT;
                end
            end
            default: ;
        endcase
        // bang-bang decision on the wrapping error
        if (ctl_mode == MODE_MOVING) begin
            diff = target_pos - enc_position;
            neg  = diff[POS_W-1];
            mag  = neg ? -diff : diff;
            if (mag < POS_W'(deadband_now)) begin
                motor_on = 1'b0;
                ctl_mode = MODE_READY;
            end else begin
                motor_on  = 1'b1;
                motor_fwd = !neg && (diff != '0);
            end
        end
        r.motor_run     = motor_on;
        r.drive_fwd     = motor_fwd;
        r.drive_compare = motor_on ? speed_now : '0;
        r.busy_res      = (ctl_mode != MODE_READY);
        r.mode          = ctl_mode;
        r.position      = enc_position;
        return r;
    endfunction

    // next random event: frames aimed near the position, edges that follow the motor
    function automatic t_in_item next_event();
        t_in_item         ev;
        logic [POS_W-1:0] span;
        logic [POS_W-1:0] aim;
        int               roll;
        ev.command     = CMD_TICK;
        ev.data_byte   = 8'($urandom);
        ev.encoder_dir = 1'($urandom);
        roll = $urandom_range(0, 99);
        if (ctl_mode == MODE_MOVING) begin
            if (roll < 70) begin
                ev.command     = CMD_ENCODER;
                ev.encoder_dir = motor_fwd;
            end else if (roll < 85) begin
                ev.command     = CMD_ENCODER;
                ev.encoder_dir = ~motor_fwd;
            end else if (roll >= 95) begin
                ev.command = CMD_BYTE;
            end
        end else if (frame_bytes.size() != 0 && roll < 85) begin
            ev.command   = CMD_BYTE;
            ev.data_byte = frame_bytes.pop_front();
        end else if (frame_bytes.size() == 0 && roll < 75) begin
            span = POS_W'(deadband_now) + 40;
            if ($urandom_range(0, 1) != 0)
                aim = enc_position + $urandom_range(0, span);
            else
                aim = enc_position - $urandom_range(0, span);
            if ($urandom_range(0, 15) == 0)
                aim[7:0] = 8'($urandom);
            for (int k = 0; k < TARGET_LANES; k++)
                frame_bytes.push_back(aim[k*BYTE_W +: BYTE_W]);
            ev.command   = CMD_BYTE;
            ev.data_byte = frame_bytes.pop_front();
        end else if ($urandom_range(0, 1) != 0) begin
            ev.command = CMD_ENCODER;
        end
        return ev;
    endfunction

    // offer one item, wait for it to be taken, queue its drive report
    task automatic apply_event(input t_in_item ev, input logic given, input t_out_item want);
        t_out_item r;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= ev;
        do @(posedge i_clk); while (o_in_stall);
        r = step_controller(ev);
        drive_reports.push_back(given ? want : r);
    endtask

    // register write, setup then access
    task automatic write_reg(input t_reg_idx idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // new settings once every report is back
    task automatic set_config(input int deadband, input int speed);
        i_in_valid <= 1'b0;
        while (drive_reports.size() != 0) @(posedge i_clk);
        write_reg(REG_DEADBAND, APB_DATA_W'(deadband));
        deadband_now = DEADBAND_W'(deadband);
        write_reg(REG_SPEED, APB_DATA_W'(speed));
        speed_now = SPEED_W'(speed);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // report side stalls in short bursts
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left  <= $urandom_range(0, 3);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // compare each report with the oldest one due
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (drive_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("report with none due: %p", o_out_data);
            end else begin
                report_due = drive_reports.pop_front();
                if (o_out_data.motor_run !== report_due.motor_run ||
                    o_out_data.drive_fwd !== report_due.drive_fwd ||
                    o_out_data.drive_compare !== report_due.drive_compare ||
                    o_out_data.busy_res !== report_due.busy_res ||
                    o_out_data.mode !== report_due.mode ||
                    o_out_data.position !== report_due.position) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("report differs: expected %p, got %p",
                                 report_due, o_out_data);
                end
            end
        end
    end

    initial begin
        logic [POS_W-1:0] aim;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table under reset settings
        for (int row = 0; row < DIRECTED_ROWS; row++)
            apply_event(event_table[row].ev, event_table[row].given, event_table[row].want);

        // random phases, moves steered to an end before the settings change (not under a zero deadband)
        for (int ph = 0; ph < N_PHASES; ph++) begin
            set_config(PHASE_DEADBAND[ph], PHASE_SPEED[ph]);
            for (int n = 0; n < PHASE_ITEMS[ph]; n++) begin
                if (n % 40 == 0)
                    idle_on = (ph != N_PHASES - 1) && ($urandom_range(0, 3) != 0);
                apply_event(next_event(), 1'b0, NONE);
            end
            while (deadband_now != 0 && (ctl_mode == MODE_MOVING || frame_count != 0))
                apply_event(next_event(), 1'b0, NONE);
        end

        // most negative error: target half a turn away, runs in reverse
        aim = enc_position + 32'h8000_0000;
        for (int k = 0; k < TARGET_LANES; k++)
            apply_event('{CMD_BYTE, aim[k*BYTE_W +: BYTE_W], 1'($urandom)}, 1'b0, NONE);
        for (int row = DIRECTED_ROWS; row < TABLE_ROWS; row++)
            apply_event(event_table[row].ev, event_table[row].given, event_table[row].want);
        i_in_valid <= 1'b0;

        while (drive_reports.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0)
            $display("homing_bang_bang_position_controller: match");
        else
            $display("homing_bang_bang_position_controller: mismatch");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("homing_bang_bang_position_controller: mismatch");
        $finish;
    end

endmodule
